// File: rtl/tcf_pkg.sv
package tcf_pkg;

   // telnet command codes
   localparam logic [7:0] CODE_IAC  = 8'd255;
   localparam logic [7:0] CODE_WILL = 8'd251;
   localparam logic [7:0] CODE_WONT = 8'd252;
   localparam logic [7:0] CODE_DO   = 8'd253;
   localparam logic [7:0] CODE_DONT = 8'd254;

   // options that are left alone
   localparam logic [7:0] OPT_BINARY = 8'd0;
   localparam logic [7:0] OPT_ECHO   = 8'd1;
   localparam logic [7:0] OPT_SGA    = 8'd3;

   // action queue between front and back, depth a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   // refusal bursts are three bytes
   localparam int               SEQ_W    = 2;
   localparam logic [SEQ_W-1:0] SEQ_IAC  = 2'd0;
   localparam logic [SEQ_W-1:0] SEQ_CODE = 2'd1;
   localparam logic [SEQ_W-1:0] SEQ_OPT  = 2'd2;

   // one unit of work for the back end
   typedef struct packed {
      logic       is_refusal;  // 0: one data byte, 1: three-byte refusal
      logic [7:0] value;       // data byte, or option being refused
      logic [7:0] reply_code;  // DONT or WONT for a refusal
   } action_type;

endpackage

// File: rtl/telnet_command_filter.sv
// channel   | ports                                     | transaction when
// ----------+-------------------------------------------+------------------------------
// request   | req_push, req_full, req_rx_byte           | req_push && !req_full
// response  | rsp_empty, rsp_pop, rsp_dest,             | rsp_pop && !rsp_empty
//           | rsp_out_byte, rsp_last                    |
//
// one request byte per cycle while req_full is low; a refusal is three bytes from the
// back end; it drains the action queue one output byte per cycle when rsp_pop is high
// a result reaches the response ports through the action queue and the output register
// req_full follows the action queue (four entries) being full
// synchronous active-high reset clears parse state, queue, refusal sequence and output valid flag
// the front end keeps taking bytes while the response side stalls until the queue fills
module telnet_command_filter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_dest,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   logic                accept;
   logic                act_valid;
   tcf_pkg::action_type act;
   tcf_pkg::action_type head;
   logic                q_empty;
   logic                head_pop;

   // a byte is taken whenever the queue has room, even if it yields no action
   assign accept = req_push && !req_full;

   // parse state machine and classification
   tcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .act_valid (act_valid),
      .act       (act)
   );

   // decouples parsing from output sequencing
   tcf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && act_valid),
      .push_data (act),
      .full      (req_full),
      .pop       (head_pop),
      .pop_data  (head),
      .empty     (q_empty)
   );

   // expands actions into response bytes through an output register
   tcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_empty),
      .head       (head),
      .head_pop   (head_pop),
      .out_empty  (rsp_empty),
      .out_pop    (rsp_pop),
      .out_dest   (rsp_dest),
      .out_byte   (rsp_out_byte),
      .out_last   (rsp_last)
   );

endmodule

// File: rtl/tcf_front.sv
module tcf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   output logic                act_valid,
   output tcf_pkg::action_type act
);

   localparam logic [2:0] PS_NORMAL = 3'd0;
   localparam logic [2:0] PS_IAC    = 3'd1;
   localparam logic [2:0] PS_WILL   = 3'd2;
   localparam logic [2:0] PS_WONT   = 3'd3;
   localparam logic [2:0] PS_DO     = 3'd4;
   localparam logic [2:0] PS_DONT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       opt_ok;

   assign opt_ok = rx_byte inside {tcf_pkg::OPT_BINARY, tcf_pkg::OPT_ECHO, tcf_pkg::OPT_SGA};

   always_comb begin
      state_in       = PS_NORMAL;
      act_valid      = 1'b0;
      act.is_refusal = 1'b0;
      act.value      = rx_byte;
      act.reply_code = tcf_pkg::CODE_DONT;
      case (state_ff)
         PS_NORMAL: begin
            if (rx_byte == tcf_pkg::CODE_IAC) begin
               state_in = PS_IAC;
            end else begin
               act_valid = 1'b1;
            end
         end
         PS_IAC: begin
            case (rx_byte)
               tcf_pkg::CODE_IAC:  act_valid = 1'b1;
               tcf_pkg::CODE_WILL: state_in  = PS_WILL;
               tcf_pkg::CODE_WONT: state_in  = PS_WONT;
               tcf_pkg::CODE_DO:   state_in  = PS_DO;
               tcf_pkg::CODE_DONT: state_in  = PS_DONT;
               default:            state_in  = PS_NORMAL;
            endcase
         end
         PS_WILL: begin
            act_valid      = !opt_ok;
            act.is_refusal = 1'b1;
            act.reply_code = tcf_pkg::CODE_DONT;
         end
         PS_DO: begin
            act_valid      = !opt_ok;
            act.is_refusal = 1'b1;
            act.reply_code = tcf_pkg::CODE_WONT;
         end
         default: begin
            // option after wont/dont and unused codes: swallowed
            state_in = PS_NORMAL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PS_NORMAL;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/tcf_queue.sv
module tcf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tcf_pkg::action_type push_data,
   output logic                full,
   input  logic                pop,
   output tcf_pkg::action_type pop_data,
   output logic                empty
);

   tcf_pkg::action_type                mem_ff [tcf_pkg::QUEUE_DEPTH];
   logic [tcf_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [tcf_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [tcf_pkg::QUEUE_CNT_W-1:0]    count_ff;
   logic                               do_push;
   logic                               do_pop;

   assign full     = count_ff == tcf_pkg::QUEUE_CNT_W'(tcf_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: rtl/tcf_back.sv
module tcf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  tcf_pkg::action_type head,
   output logic                head_pop,
   output logic                out_empty,
   input  logic                out_pop,
   output logic                out_dest,
   output logic [7:0]          out_byte,
   output logic                out_last
);

   logic [tcf_pkg::SEQ_W-1:0] seq_ff;
   logic                      out_valid_ff;
   logic                      dest_ff;
   logic [7:0]                byte_ff;
   logic                      last_ff;
   logic                      load;
   logic                      dest_in;
   logic [7:0]                byte_in;
   logic                      last_in;

   assign load     = head_valid && (!out_valid_ff || out_pop);
   assign head_pop = load && (!head.is_refusal || seq_ff == tcf_pkg::SEQ_OPT);

   always_comb begin
      dest_in = head.is_refusal;
      byte_in = head.value;
      last_in = 1'b1;
      if (head.is_refusal) begin
         case (seq_ff)
            tcf_pkg::SEQ_IAC: begin
               byte_in = tcf_pkg::CODE_IAC;
               last_in = 1'b0;
            end
            tcf_pkg::SEQ_CODE: begin
               byte_in = head.reply_code;
               last_in = 1'b0;
            end
            default: begin
               byte_in = head.value;
               last_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= tcf_pkg::SEQ_IAC;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            out_valid_ff <= 1'b1;
            seq_ff       <= head_pop ? tcf_pkg::SEQ_IAC : seq_ff + 1'b1;
         end else if (out_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dest_ff <= dest_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign out_empty = !out_valid_ff;
   assign out_dest  = dest_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

// File: dv/tb_telnet_command_filter.sv
module tb_telnet_command_filter;
   timeunit 1ns;
   timeprecision 1ps;

   // subnegotiation start, a command the filter does not know
   localparam logic [7:0] CMD_SB = 8'd250;
   localparam int ITEM_TOTAL = 480;
   localparam int TAIL_CYCLES = 20;

   // where the filter stands in the peer's byte stream
   typedef enum logic [2:0] {
      PARSE_DATA,
      PARSE_IAC,
      PARSE_WILL,
      PARSE_WONT,
      PARSE_DO,
      PARSE_DONT
   } parse_type;

   // one byte leaving the filter
   typedef struct packed {
      logic       dest;
      logic [7:0] data;
      logic       last;
   } filter_out_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_dest;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   logic [7:0]     peer_stream[$];  // bytes still to be sent by the peer
   filter_out_type owed_bytes[$];   // bytes the filter still owes, oldest first
   parse_type      parse_now = PARSE_DATA;
   int             queued = 0;
   int             fault_count = 0;
   int             send_wait = 0;
   int             take_wait = 0;
   bit             send_calm = 0;
   bit             take_calm = 0;

   telnet_command_filter dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_rx_byte  (req_rx_byte),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_dest     (rsp_dest),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------

   function automatic bit option_kept(input logic [7:0] opt);
      return opt == tcf_pkg::OPT_BINARY || opt == tcf_pkg::OPT_ECHO ||
             opt == tcf_pkg::OPT_SGA;
   endfunction

   task automatic owe(input logic dest, input logic [7:0] data, input logic last);
      filter_out_type item;
      item.dest = dest;
      item.data = data;
      item.last = last;
      owed_bytes.push_back(item);
   endtask

   // three bytes back to the peer: IAC, the negative reply, the option
   task automatic refuse(input logic [7:0] reply, input logic [7:0] opt);
      owe(1'b1, tcf_pkg::CODE_IAC, 1'b0);
      owe(1'b1, reply, 1'b0);
      owe(1'b1, opt, 1'b1);
   endtask

   // advance the parser by one received byte and queue what it emits
   task automatic filter_byte(input logic [7:0] b);
      parse_type was;
      was = parse_now;
      parse_now = PARSE_DATA;
      case (was)
         PARSE_DATA: begin
            if (b == tcf_pkg::CODE_IAC) parse_now = PARSE_IAC;
            else owe(1'b0, b, 1'b1);
         end
         PARSE_IAC: begin
            // escaped 255 goes through; unknown commands just end the sequence
            if (b == tcf_pkg::CODE_IAC) owe(1'b0, tcf_pkg::CODE_IAC, 1'b1);
            else if (b == tcf_pkg::CODE_WILL) parse_now = PARSE_WILL;
            else if (b == tcf_pkg::CODE_WONT) parse_now = PARSE_WONT;
            else if (b == tcf_pkg::CODE_DO) parse_now = PARSE_DO;
            else if (b == tcf_pkg::CODE_DONT) parse_now = PARSE_DONT;
         end
         PARSE_WILL: begin
            if (!option_kept(b)) refuse(tcf_pkg::CODE_DONT, b);
         end
         PARSE_DO: begin
            if (!option_kept(b)) refuse(tcf_pkg::CODE_WONT, b);
         end
         default: ;  // option after WONT or DONT is dropped
      endcase
   endtask

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   task automatic queue_byte(input logic [7:0] b);
      peer_stream.push_back(b);
      queued++;
   endtask

   // options lean toward the three that are left alone
   function automatic logic [7:0] pick_option();
      case ($urandom_range(0, 5))
         0: return tcf_pkg::OPT_BINARY;
         1: return tcf_pkg::OPT_ECHO;
         2: return tcf_pkg::OPT_SGA;
         3: return 8'd2;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // ---------------------------------------------------------------
   // driver: request side
   // ---------------------------------------------------------------

   always @(posedge clock) begin : send_side
      logic took;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         took = req_push && !req_full;
         if (took) filter_byte(req_rx_byte);
         if (req_push && !took) begin
            // hold the byte until the filter has room
         end else if (send_wait > 0) begin
            send_wait--;
            req_push <= 1'b0;
         end else if (peer_stream.size() > 0) begin
            req_rx_byte <= peer_stream.pop_front();
            req_push <= 1'b1;
            // occasionally switch between gappy and back-to-back sending
            if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
            send_wait = send_calm ? 0 : $urandom_range(0, 4);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: response side, checks each transaction in order
   // ---------------------------------------------------------------

   always @(posedge clock) begin : take_side
      filter_out_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (owed_bytes.size() == 0) begin
               fault_count++;
               $display("%0t: unexpected transaction, expected none, %s %0d %0d %0d",
                        $time, "got dest byte last", rsp_dest, rsp_out_byte, rsp_last);
            end else begin
               want = owed_bytes.pop_front();
               if (rsp_dest !== want.dest) begin
                  fault_count++;
                  $display("%0t: dest expected %0d, got %0d", $time, want.dest, rsp_dest);
               end
               if (rsp_out_byte !== want.data) begin
                  fault_count++;
                  $display("%0t: out_byte expected %0d, got %0d",
                           $time, want.data, rsp_out_byte);
               end
               if (rsp_last !== want.last) begin
                  fault_count++;
                  $display("%0t: last expected %0d, got %0d", $time, want.last, rsp_last);
               end
            end
            if ($urandom_range(0, 31) == 0) take_calm = !take_calm;
            take_wait = take_calm ? 0 : $urandom_range(0, 4);
         end
         // stall between transactions, otherwise keep pop high
         if (take_wait > 0) begin
            take_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // sequence: reset, directed bytes, random telnet traffic, drain
   // ---------------------------------------------------------------

   initial begin
      int kind;

      // plain data at both ends of the range
      queue_byte(8'd0);
      queue_byte(8'd254);
      // escaped 255
      queue_byte(tcf_pkg::CODE_IAC); queue_byte(tcf_pkg::CODE_IAC);
      // offer of an option that is left alone
      queue_byte(tcf_pkg::CODE_IAC); queue_byte(tcf_pkg::CODE_WILL);
      queue_byte(tcf_pkg::OPT_BINARY);
      // offer of option 255, refused with DONT
      queue_byte(tcf_pkg::CODE_IAC); queue_byte(tcf_pkg::CODE_WILL);
      queue_byte(tcf_pkg::CODE_IAC);
      // request for echo, left alone
      queue_byte(tcf_pkg::CODE_IAC); queue_byte(tcf_pkg::CODE_DO);
      queue_byte(tcf_pkg::OPT_ECHO);
      // request for terminal type, refused with WONT
      queue_byte(tcf_pkg::CODE_IAC); queue_byte(tcf_pkg::CODE_DO); queue_byte(8'd24);
      // WONT and DONT with their option are dropped
      queue_byte(tcf_pkg::CODE_IAC); queue_byte(tcf_pkg::CODE_WONT); queue_byte(8'd5);
      queue_byte(tcf_pkg::CODE_IAC); queue_byte(tcf_pkg::CODE_DONT);
      queue_byte(tcf_pkg::OPT_SGA);
      // subnegotiation start is dropped, the next byte is plain data
      queue_byte(tcf_pkg::CODE_IAC); queue_byte(CMD_SB); queue_byte(8'h41);

      // random traffic, mostly well-formed sequences
      while (queued < ITEM_TOTAL) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            queue_byte(8'($urandom_range(0, 254)));
         end else if (kind < 42) begin
            queue_byte(tcf_pkg::CODE_IAC); queue_byte(tcf_pkg::CODE_IAC);
         end else if (kind < 72) begin
            queue_byte(tcf_pkg::CODE_IAC);
            queue_byte($urandom_range(0, 1) ? tcf_pkg::CODE_WILL : tcf_pkg::CODE_DO);
            queue_byte(pick_option());
         end else if (kind < 82) begin
            queue_byte(tcf_pkg::CODE_IAC);
            queue_byte($urandom_range(0, 1) ? tcf_pkg::CODE_WONT : tcf_pkg::CODE_DONT);
            queue_byte(pick_option());
         end else if (kind < 90) begin
            // some other command
            queue_byte(tcf_pkg::CODE_IAC); queue_byte(8'($urandom_range(0, 250)));
         end else if (kind < 95) begin
            queue_byte(8'($urandom_range(0, 255)));
         end else begin
            // broken sequence: IAC followed by anything
            queue_byte(tcf_pkg::CODE_IAC); queue_byte(8'($urandom_range(0, 255)));
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // wait for every byte to be taken, then for every result
      while (peer_stream.size() != 0 || req_push) @(posedge clock);
      while (owed_bytes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (owed_bytes.size() != 0) begin
         fault_count++;
         $display("%0t: %0d results never arrived", $time, owed_bytes.size());
      end
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
